// ===== hw/rtl/mfl_pkg.sv =====
// mfl_pkg: shared widths, operation codes and structs of the mel filterbank
// log energy block. No dependencies; every other file takes names from here.
`default_nettype none
package mfl_pkg;
   localparam int OP_W      = 2;
   localparam logic [OP_W-1:0] OP_BAND_SHAPE = 2'd0;
   localparam logic [OP_W-1:0] OP_WEIGHT     = 2'd1;
   localparam logic [OP_W-1:0] OP_SPECTRUM   = 2'd2;

   localparam int BAND_W    = 5;
   localparam int BIN_W     = 10;
   localparam int CNT_W     = 10;
   localparam int SLOT_W    = 10;
   localparam int WVAL_W    = 16;
   localparam int PART_W    = 32;
   localparam int LOG_W     = 15;
   localparam int CFG_W     = 6;
   localparam logic [CFG_W-1:0] BANDS_RESET = 6'd30;

   localparam int RESULT_CAP = 32;
   localparam int FIFO_AW    = 5;
   localparam int POW_W      = 64;
   localparam int MANT_W     = 32;
   localparam int EXP_W      = 6;
   localparam int NORM_STAGES = 6;
   localparam int FRAC_BITS  = 20;
   localparam int LG_W       = EXP_W + FRAC_BITS;
   localparam int PROD_W     = LG_W + 32;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   // first_bin plus offset inside a band
   localparam int WALK_BIN_W = 11;

   typedef struct packed {
      logic              valid;
      logic [BAND_W-1:0] band;
      logic              last;
   } log_tag_type;

   typedef struct packed {
      logic [BAND_W-1:0] band_out;
      logic [LOG_W-1:0]  log_energy;
      logic              last_band;
   } result_type;
endpackage
`default_nettype wire

// ===== hw/rtl/mfl_if.sv =====
// mfl channel interfaces: request, response and register write channels.
// Depends on mfl_pkg for field widths.
`default_nettype none
interface mfl_req_if;
   logic                             valid;
   logic                             ready;
   logic [mfl_pkg::OP_W-1:0]         operation;
   logic [mfl_pkg::BAND_W-1:0]       band_number;
   logic [mfl_pkg::BIN_W-1:0]        first_bin;
   logic [mfl_pkg::CNT_W-1:0]        weight_count;
   logic [mfl_pkg::SLOT_W-1:0]       weight_slot;
   logic [mfl_pkg::WVAL_W-1:0]       weight_value;
   logic signed [mfl_pkg::PART_W-1:0] real_part;
   logic signed [mfl_pkg::PART_W-1:0] imag_part;
   modport source (output valid, operation, band_number, first_bin, weight_count,
                   weight_slot, weight_value, real_part, imag_part, input ready);
   modport sink (input valid, operation, band_number, first_bin, weight_count,
                 weight_slot, weight_value, real_part, imag_part, output ready);
endinterface

interface mfl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mfl_pkg::BAND_W-1:0]  band_out;
   logic [mfl_pkg::LOG_W-1:0]   log_energy;
   logic                        last_band;
   modport source (output valid, band_out, log_energy, last_band, input ready);
   modport sink (input valid, band_out, log_energy, last_band, output ready);
endinterface

interface mfl_csr_if;
   logic                       valid;
   logic                       ready;
   logic [mfl_pkg::CFG_W-1:0]  bands_in_use;
   modport source (output valid, bands_in_use, input ready);
   modport sink (input valid, bands_in_use, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mfl_norm.sv =====
// mfl_norm: pipelined leading-one search, one binary step per stage.
// Gives the Q1.31 mantissa and exponent of a nonzero 64-bit sum. Uses mfl_pkg.
`default_nettype none
module mfl_norm (
   input  logic                         clock,
   input  logic                         reset,
   input  mfl_pkg::log_tag_type         tag_i,
   input  logic [mfl_pkg::POW_W-1:0]    x_i,
   output mfl_pkg::log_tag_type         tag_o,
   output logic [mfl_pkg::MANT_W-1:0]   mant_o,
   output logic [mfl_pkg::EXP_W-1:0]    expo_o
);
   mfl_pkg::log_tag_type            tag_ff [mfl_pkg::NORM_STAGES];
   logic [mfl_pkg::POW_W-1:0]       x_ff   [mfl_pkg::NORM_STAGES];
   logic [mfl_pkg::EXP_W-1:0]       lz_ff  [mfl_pkg::NORM_STAGES];

   for (genvar k = 0; k < mfl_pkg::NORM_STAGES; k++) begin : g_stage
      localparam int SH = (mfl_pkg::POW_W / 2) >> k;
      mfl_pkg::log_tag_type       tag_src;
      logic [mfl_pkg::POW_W-1:0]  x_src;
      logic [mfl_pkg::EXP_W-1:0]  lz_src;
      logic [mfl_pkg::POW_W-1:0]  x_in;
      logic [mfl_pkg::EXP_W-1:0]  lz_in;

      if (k == 0) begin : g_first
         assign tag_src = tag_i;
         assign x_src   = x_i;
         assign lz_src  = '0;
      end else begin : g_next
         assign tag_src = tag_ff[k-1];
         assign x_src   = x_ff[k-1];
         assign lz_src  = lz_ff[k-1];
      end

      always_comb begin
         x_in  = x_src;
         lz_in = lz_src;
         if (x_src[mfl_pkg::POW_W-1 -: SH] == '0) begin
            x_in  = x_src << SH;
            lz_in = lz_src | mfl_pkg::EXP_W'(SH);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else begin
            tag_ff[k] <= tag_src;
         end
         x_ff[k]  <= x_in;
         lz_ff[k] <= lz_in;
      end
   end

   assign tag_o  = tag_ff[mfl_pkg::NORM_STAGES-1];
   assign mant_o = x_ff[mfl_pkg::NORM_STAGES-1][mfl_pkg::POW_W-1 -: mfl_pkg::MANT_W];
   // exponent is 63 minus the leading zero count
   assign expo_o = ~lz_ff[mfl_pkg::NORM_STAGES-1];
endmodule
`default_nettype wire

// ===== hw/rtl/mfl_cell.sv =====
// mfl_cell: one log2 fraction bit by squaring the Q1.31 mantissa.
// Cells chain in mfl_log, each handing its mantissa on every cycle. Uses mfl_pkg.
`default_nettype none
module mfl_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  mfl_pkg::log_tag_type            tag_i,
   input  logic [mfl_pkg::MANT_W-1:0]      mant_i,
   input  logic [mfl_pkg::EXP_W-1:0]       expo_i,
   input  logic [mfl_pkg::FRAC_BITS-1:0]   frac_i,
   output mfl_pkg::log_tag_type            tag_o,
   output logic [mfl_pkg::MANT_W-1:0]      mant_o,
   output logic [mfl_pkg::EXP_W-1:0]       expo_o,
   output logic [mfl_pkg::FRAC_BITS-1:0]   frac_o
);
   localparam int SQ_W = 2 * mfl_pkg::MANT_W;

   mfl_pkg::log_tag_type                tag_ff;
   logic [mfl_pkg::MANT_W-1:0]          mant_ff;
   logic [mfl_pkg::MANT_W-1:0]          mant_in;
   logic [mfl_pkg::EXP_W-1:0]           expo_ff;
   logic [mfl_pkg::FRAC_BITS-1:0]       frac_ff;
   logic [mfl_pkg::FRAC_BITS-1:0]       frac_in;
   logic [SQ_W-1:0]                     sq;
   logic                                bit_set;

   assign sq      = SQ_W'(mant_i) * SQ_W'(mant_i);
   // square is Q2.62; at or above 2.0 the bit is set and we halve
   assign bit_set = sq[SQ_W-1];
   assign mant_in = bit_set ? sq[SQ_W-1 -: mfl_pkg::MANT_W] : sq[SQ_W-2 -: mfl_pkg::MANT_W];
   assign frac_in = {frac_i[mfl_pkg::FRAC_BITS-2:0], bit_set};

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_i;
      end
      mant_ff <= mant_in;
      expo_ff <= expo_i;
      frac_ff <= frac_in;
   end

   assign tag_o  = tag_ff;
   assign mant_o = mant_ff;
   assign expo_o = expo_ff;
   assign frac_o = frac_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/mfl_log.sv =====
// mfl_log: natural log of a band sum as Q6.9: normalizer, a chain of squaring
// cells and a ln2 scaling multiply. Uses mfl_pkg, mfl_norm and mfl_cell.
`default_nettype none
module mfl_log (
   input  logic                        clock,
   input  logic                        reset,
   input  mfl_pkg::log_tag_type        tag_i,
   input  logic [mfl_pkg::POW_W-1:0]   x_i,
   output logic                        valid_o,
   output mfl_pkg::result_type         result_o
);
   localparam int F = mfl_pkg::FRAC_BITS;

   mfl_pkg::log_tag_type             tag_c  [F+1];
   logic [mfl_pkg::MANT_W-1:0]       mant_c [F+1];
   logic [mfl_pkg::EXP_W-1:0]        expo_c [F+1];
   logic [F-1:0]                     frac_c [F+1];

   mfl_pkg::log_tag_type             ptag_ff;
   logic [mfl_pkg::PROD_W-1:0]       prod_ff;
   logic [mfl_pkg::PROD_W-1:0]       prod_in;
   logic [mfl_pkg::PROD_W-1:0]       rnd;
   logic [mfl_pkg::LG_W-1:0]         lg;
   logic                             out_v_ff;
   mfl_pkg::result_type              out_ff;

   mfl_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .tag_i  (tag_i),
      .x_i    (x_i),
      .tag_o  (tag_c[0]),
      .mant_o (mant_c[0]),
      .expo_o (expo_c[0])
   );
   assign frac_c[0] = '0;

   for (genvar k = 0; k < F; k++) begin : g_cell
      mfl_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .tag_i  (tag_c[k]),
         .mant_i (mant_c[k]),
         .expo_i (expo_c[k]),
         .frac_i (frac_c[k]),
         .tag_o  (tag_c[k+1]),
         .mant_o (mant_c[k+1]),
         .expo_o (expo_c[k+1]),
         .frac_o (frac_c[k+1])
      );
   end

   assign lg      = {expo_c[F], frac_c[F]};
   assign prod_in = mfl_pkg::PROD_W'(lg) * mfl_pkg::PROD_W'(mfl_pkg::LN2_Q32);
   // round half up, keep 9 fractional bits of the Q.52 product
   assign rnd     = prod_ff + (mfl_pkg::PROD_W'(1) << 42);

   always_ff @(posedge clock) begin
      if (reset) begin
         ptag_ff  <= '0;
         out_v_ff <= 1'b0;
      end else begin
         ptag_ff  <= tag_c[F];
         out_v_ff <= ptag_ff.valid;
      end
      prod_ff             <= prod_in;
      out_ff.band_out     <= ptag_ff.band;
      out_ff.last_band    <= ptag_ff.last;
      out_ff.log_energy   <= rnd[57:43];
   end

   assign valid_o  = out_v_ff;
   assign result_o = out_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/mel_filterbank_log_energy_core.sv =====
// Mel filterbank log energy core. Band shapes (op 0) and weights (op 1) are
// taken one per cycle, as are spectrum words (op 2), while ready is high; the
// power of each bin goes through a squaring stage into a power memory. After
// the last word of a frame the block stops taking items and walks the bands:
// per band the fetch and setup states read its shape, the walk state issues
// one weight per cycle (one read of the power and weight memories each), and
// the drain state lets the multiply-add empty. Each band sum then runs
// through a 28-stage log pipeline (normalizer, a chain of 20 squaring cells
// and the ln2 multiply) into a 32-entry result queue. The last word of the
// next frame is held off until that queue is empty. No clearing pass.
// Depends on mfl_pkg, mfl_if and mfl_log.
`default_nettype none
module mel_filterbank_log_energy_core #(
   parameter int FFT_LENGTH   = 1024,
   parameter int MAX_BANDS    = 32,
   parameter int WEIGHT_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   mfl_req_if.sink      req_bus,
   mfl_rsp_if.source    rsp_bus,
   mfl_csr_if.sink      csr_bus
);
   localparam int HALF_LEN = FFT_LENGTH / 2;
   localparam int PADDR_W  = $clog2(HALF_LEN);
   localparam int WADDR_W  = $clog2(WEIGHT_DEPTH);
   localparam int BADDR_W  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int NB_CAP   = (MAX_BANDS < mfl_pkg::RESULT_CAP) ? MAX_BANDS
                                                                : mfl_pkg::RESULT_CAP;
   localparam int BT_W     = mfl_pkg::BIN_W + mfl_pkg::CNT_W;
   localparam int NB_W     = mfl_pkg::BAND_W + 1;
   localparam int P_W      = mfl_pkg::POW_W;
   localparam int HW       = P_W / 2;
   localparam int MP_W     = HW + mfl_pkg::WVAL_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FETCH = 5'b00010,
      S_SETUP = 5'b00100,
      S_WALK  = 5'b01000,
      S_DRAIN = 5'b10000
   } walk_state_type;

   // memories
   logic [BT_W-1:0]            band_mem   [MAX_BANDS];
   logic [mfl_pkg::WVAL_W-1:0] weight_mem [WEIGHT_DEPTH];
   logic [P_W-1:0]             power_mem  [HALF_LEN];
   logic [BT_W-1:0]            band_rd_ff;
   logic [mfl_pkg::WVAL_W-1:0] wdata_ff;
   logic [P_W-1:0]             pdata_ff;
   logic [P_W-1:0]             nyq_ff;

   // config and input side
   logic [mfl_pkg::CFG_W-1:0]  bands_ff;
   logic                       busy_ff;
   logic [PADDR_W-1:0]         wc_ff;
   logic                       word_last;
   logic                       acc;
   logic                       band_we;
   logic                       weight_we;
   logic                       spec_acc;
   logic [31:0]                band_wa_wide;
   logic [31:0]                slot_wa_wide;
   logic [31:0]                band_ra_wide;
   logic [mfl_pkg::PART_W-1:0] re_mag;
   logic [mfl_pkg::PART_W-1:0] im_mag;

   // power squaring stage
   logic                       pa_v_ff;
   logic [P_W-1:0]             pa_re_ff;
   logic [P_W-1:0]             pa_im_ff;
   logic                       pa_first_ff;
   logic                       pa_last_ff;
   logic [PADDR_W-1:0]         pa_addr_ff;
   logic                       pass_start;

   // band walk
   walk_state_type             state_ff;
   walk_state_type             state_in;
   logic [NB_W-1:0]            band_ff;
   logic [NB_W-1:0]            band_in;
   logic [NB_W-1:0]            nb_ff;
   logic [NB_W-1:0]            nb_in;
   logic [mfl_pkg::WALK_BIN_W-1:0] bin_ff;
   logic [mfl_pkg::WALK_BIN_W-1:0] bin_in;
   logic [mfl_pkg::CNT_W-1:0]  left_ff;
   logic [mfl_pkg::CNT_W-1:0]  left_in;
   logic [WADDR_W-1:0]         slot_ff;
   logic [WADDR_W-1:0]         slot_in;
   logic [WADDR_W-1:0]         slot_next;
   logic                       issue;
   logic                       band_done;
   logic                       band_is_last;

   logic                       rd_v_ff;
   logic                       rd_use_ff;
   logic                       rd_nyq_ff;
   logic                       mul_v_ff;
   logic [MP_W-1:0]            mhi_ff;
   logic [MP_W-1:0]            mlo_ff;
   logic [P_W-1:0]             mul_p;
   logic [mfl_pkg::WVAL_W-1:0] mul_w;
   logic [P_W-1:0]             term;
   logic [P_W:0]               sum_wide;
   logic [P_W-1:0]             sum_ff;
   logic [P_W-1:0]             sum_in;

   // log unit and result queue
   mfl_pkg::log_tag_type       log_tag;
   logic [P_W-1:0]             log_x;
   logic                       log_v;
   mfl_pkg::result_type        log_res;
   mfl_pkg::result_type        fifo_mem [mfl_pkg::RESULT_CAP];
   logic [mfl_pkg::FIFO_AW-1:0] wr_ptr_ff;
   logic [mfl_pkg::FIFO_AW-1:0] rd_ptr_ff;
   logic [mfl_pkg::FIFO_AW:0]   cnt_ff;
   logic                       pop;

   // ---------------- input side ----------------
   assign csr_bus.ready = 1'b1;
   assign word_last     = (wc_ff == PADDR_W'(HALF_LEN - 1));
   assign req_bus.ready = !busy_ff && !(word_last && (cnt_ff != '0));
   assign acc           = req_bus.valid && req_bus.ready;
   assign band_wa_wide  = 32'(req_bus.band_number);
   assign slot_wa_wide  = 32'(req_bus.weight_slot);
   assign band_we   = acc && (req_bus.operation == mfl_pkg::OP_BAND_SHAPE)
                      && (band_wa_wide < 32'(MAX_BANDS));
   assign weight_we = acc && (req_bus.operation == mfl_pkg::OP_WEIGHT)
                      && (slot_wa_wide < 32'(WEIGHT_DEPTH));
   assign spec_acc  = acc && (req_bus.operation == mfl_pkg::OP_SPECTRUM);

   assign re_mag = req_bus.real_part[mfl_pkg::PART_W-1] ? (~req_bus.real_part + 1'b1)
                                                        : req_bus.real_part;
   assign im_mag = req_bus.imag_part[mfl_pkg::PART_W-1] ? (~req_bus.imag_part + 1'b1)
                                                        : req_bus.imag_part;

   always_ff @(posedge clock) begin
      if (reset) begin
         bands_ff <= mfl_pkg::BANDS_RESET;
         wc_ff    <= '0;
         pa_v_ff  <= 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            bands_ff <= csr_bus.bands_in_use;
         end
         if (spec_acc) begin
            wc_ff <= word_last ? '0 : wc_ff + 1'b1;
         end
         pa_v_ff <= spec_acc;
      end
      pa_re_ff    <= P_W'(re_mag) * P_W'(re_mag);
      pa_im_ff    <= P_W'(im_mag) * P_W'(im_mag);
      pa_first_ff <= (wc_ff == '0);
      pa_last_ff  <= word_last;
      pa_addr_ff  <= wc_ff;
   end

   assign pass_start = pa_v_ff && pa_last_ff;

   // ---------------- memories ----------------
   assign band_ra_wide = 32'(band_ff);

   always_ff @(posedge clock) begin
      if (band_we) begin
         band_mem[band_wa_wide[BADDR_W-1:0]] <= {req_bus.first_bin, req_bus.weight_count};
      end
      band_rd_ff <= band_mem[band_ra_wide[BADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (weight_we) begin
         weight_mem[slot_wa_wide[WADDR_W-1:0]] <= req_bus.weight_value;
      end
      wdata_ff <= weight_mem[slot_ff];
   end

   // word 0 carries DC into entry 0 and Nyquist into its own register
   always_ff @(posedge clock) begin
      if (pa_v_ff) begin
         power_mem[pa_addr_ff] <= pa_first_ff ? pa_re_ff : pa_re_ff + pa_im_ff;
      end
      pdata_ff <= power_mem[bin_ff[PADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (pa_v_ff && pa_first_ff) begin
         nyq_ff <= pa_im_ff;
      end
   end

   // ---------------- band walk ----------------
   assign issue        = (state_ff == S_WALK) && (left_ff != '0);
   assign band_done    = (state_ff == S_DRAIN) && !rd_v_ff && !mul_v_ff;
   assign band_is_last = ((band_ff + 1'b1) == nb_ff);
   assign slot_next    = (slot_ff == WADDR_W'(WEIGHT_DEPTH - 1)) ? '0 : slot_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      band_in  = band_ff;
      nb_in    = nb_ff;
      bin_in   = bin_ff;
      left_in  = left_ff;
      slot_in  = slot_ff;
      case (state_ff)
         S_IDLE: begin
            if (pass_start) begin
               band_in  = '0;
               slot_in  = '0;
               state_in = S_FETCH;
               if (bands_ff == '0) begin
                  nb_in = NB_W'(1);
               end else if (32'(bands_ff) > 32'(NB_CAP)) begin
                  nb_in = NB_W'(NB_CAP);
               end else begin
                  nb_in = NB_W'(bands_ff);
               end
            end
         end
         S_FETCH: begin
            state_in = S_SETUP;
         end
         S_SETUP: begin
            bin_in   = mfl_pkg::WALK_BIN_W'(band_rd_ff[BT_W-1 -: mfl_pkg::BIN_W]);
            left_in  = band_rd_ff[mfl_pkg::CNT_W-1:0];
            state_in = S_WALK;
         end
         S_WALK: begin
            if (issue) begin
               bin_in  = bin_ff + 1'b1;
               left_in = left_ff - 1'b1;
               slot_in = slot_next;
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (band_done) begin
               if (band_is_last) begin
                  state_in = S_IDLE;
               end else begin
                  band_in  = band_ff + 1'b1;
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // weighted term: floor(p * w / 2^16) from two 32x16 products
   assign mul_p    = rd_nyq_ff ? nyq_ff : pdata_ff;
   assign mul_w    = rd_use_ff ? wdata_ff : '0;
   assign term     = (P_W'(mhi_ff) << 16) + P_W'(mlo_ff[MP_W-1:16]);
   assign sum_wide = (P_W+1)'(sum_ff) + (P_W+1)'(term);

   always_comb begin
      sum_in = sum_ff;
      if (state_ff == S_SETUP) begin
         sum_in = '0;
      end else if (mul_v_ff) begin
         sum_in = sum_wide[P_W] ? '1 : sum_wide[P_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         rd_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_v_ff  <= issue;
         mul_v_ff <= rd_v_ff;
         if (spec_acc && word_last) begin
            busy_ff <= 1'b1;
         end else if (log_v && log_res.last_band) begin
            busy_ff <= 1'b0;
         end
      end
      band_ff   <= band_in;
      nb_ff     <= nb_in;
      bin_ff    <= bin_in;
      left_ff   <= left_in;
      slot_ff   <= slot_in;
      sum_ff    <= sum_in;
      rd_use_ff <= (32'(bin_ff) <= 32'(HALF_LEN));
      rd_nyq_ff <= (32'(bin_ff) == 32'(HALF_LEN));
      mhi_ff    <= MP_W'(mul_p[P_W-1:HW]) * MP_W'(mul_w);
      mlo_ff    <= MP_W'(mul_p[HW-1:0]) * MP_W'(mul_w);
   end

   // ---------------- log unit ----------------
   assign log_tag.valid = band_done;
   assign log_tag.band  = band_ff[mfl_pkg::BAND_W-1:0];
   assign log_tag.last  = band_is_last;
   assign log_x         = (sum_ff == '0) ? P_W'(1) : sum_ff;

   mfl_log u_log (
      .clock    (clock),
      .reset    (reset),
      .tag_i    (log_tag),
      .x_i      (log_x),
      .valid_o  (log_v),
      .result_o (log_res)
   );

   // ---------------- result queue ----------------
   assign pop           = rsp_bus.valid && rsp_bus.ready;
   assign rsp_bus.valid = (cnt_ff != '0);
   assign rsp_bus.band_out   = fifo_mem[rd_ptr_ff].band_out;
   assign rsp_bus.log_energy = fifo_mem[rd_ptr_ff].log_energy;
   assign rsp_bus.last_band  = fifo_mem[rd_ptr_ff].last_band;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (log_v) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (log_v && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !log_v) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (log_v) begin
         fifo_mem[wr_ptr_ff] <= log_res;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/mfl_check.sv =====
// mfl_check: port-level checks of the mel filterbank core, bound to the top.
// Depends on mfl_pkg and mel_filterbank_log_energy_core.
`default_nettype none
module mfl_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [mfl_pkg::BAND_W-1:0]  rsp_band_out,
   input logic                        rsp_last_band,
   input logic                        csr_valid,
   input logic                        csr_ready
);
   logic [mfl_pkg::BAND_W-1:0] exp_band_ff;

   // band expected on the next response transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_band_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         exp_band_ff <= rsp_last_band ? '0 : exp_band_ff + 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_band_out))
      else $error("response dropped or changed while stalled");

   a_band_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_band_out == exp_band_ff)
      else $error("band results out of order");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");
endmodule

bind mel_filterbank_log_energy_core mfl_check u_mfl_check (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_band_out  (rsp_bus.band_out),
   .rsp_last_band (rsp_bus.last_band),
   .csr_valid     (csr_bus.valid),
   .csr_ready     (csr_bus.ready)
);
`default_nettype wire

// ===== tb/mel_filterbank_log_energy_core_tb.sv =====
// Testbench for mel_filterbank_log_energy_core: directed table, then random frames,
// each checked against an in-bench predictor of the band log energies.
// Depends on mfl_pkg, the mfl channel interfaces and the core RTL.
`default_nettype none
module mel_filterbank_log_energy_core_tb;

   localparam int HALF_BINS   = 512;
   localparam int N_BANDS     = 32;
   localparam int N_SLOTS     = 1024;
   localparam int IDLE_LIMIT  = 200000;
   localparam int DRAIN_WAIT  = 100;
   localparam logic [63:0] LN2_FIXED = 64'd2977044472;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [mfl_pkg::OP_W-1:0]   op;
      logic [mfl_pkg::BAND_W-1:0] band;
      logic [mfl_pkg::BIN_W-1:0]  first;
      logic [mfl_pkg::CNT_W-1:0]  cnt;
      logic [mfl_pkg::SLOT_W-1:0] slot;
      logic [mfl_pkg::WVAL_W-1:0] wval;
      logic [31:0]                re;
      logic [31:0]                im;
   } req_item_type;

   typedef struct {
      req_item_type              it;
      int                        reps;
      bit                        has_exp;
      logic [mfl_pkg::LOG_W-1:0] exp_log;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mfl_req_if req_bus ();
   mfl_rsp_if rsp_bus ();
   mfl_csr_if csr_bus ();

   mel_filterbank_log_energy_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [63:0]                bin_power [0:HALF_BINS];
   logic [mfl_pkg::WVAL_W-1:0] filt_weight [0:N_SLOTS-1];
   logic [mfl_pkg::BIN_W-1:0]  shape_first [0:N_BANDS-1];
   logic [mfl_pkg::CNT_W-1:0]  shape_count [0:N_BANDS-1];
   int                         word_pos;
   int                         bands_cfg;
   mfl_pkg::result_type        band_energy_q [$];

   bit                        pinned_valid;
   logic [mfl_pkg::LOG_W-1:0] pinned_log;
   int  errors, idle_cycles, rsp_hold, frames_done, results_seen, items_sent;
   bit  no_gaps;

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   function automatic logic [63:0] square_mag(input logic [31:0] v);
      logic [63:0] a;
      a = v[31] ? 64'(-$signed(v)) : 64'(v);
      a = a & 64'hFFFF_FFFF;
      if (v == 32'h8000_0000) a = 64'h8000_0000;
      return a * a;
   endfunction

   function automatic logic [mfl_pkg::LOG_W-1:0] ln_q9_of(input logic [63:0] x);
      int          e, k;
      logic [63:0] m, lg, prod;
      logic [127:0] sq;
      if (x == 0) x = 1;
      e = 63;
      while (x[e] == 1'b0) e--;
      if (e >= 31) m = x >> (e - 31);
      else m = x << (31 - e);
      lg = 64'(e) << mfl_pkg::FRAC_BITS;
      for (k = mfl_pkg::FRAC_BITS - 1; k >= 0; k--) begin
         sq = (128'(m) * 128'(m)) >> 31;
         m = sq[63:0];
         if (m >= 64'h1_0000_0000) begin
            lg[k] = 1'b1;
            m = m >> 1;
         end
      end
      prod = lg * LN2_FIXED + (64'd1 << 42);
      return mfl_pkg::LOG_W'(prod >> 43);
   endfunction

   task automatic predict_band_energies();
      int                  nb, b, j, bin, slot;
      logic [63:0]         sum, t, p;
      logic [64:0]         s2;
      mfl_pkg::result_type r;
      nb = bands_cfg < 1 ? 1 : (bands_cfg > N_BANDS ? N_BANDS : bands_cfg);
      slot = 0;
      for (b = 0; b < nb; b++) begin
         sum = 0;
         for (j = 0; j < shape_count[b]; j++) begin
            bin = shape_first[b] + j;
            if (bin <= HALF_BINS) begin
               p = bin_power[bin];
               t = ((64'(p[63:32]) * filt_weight[slot]) << 16)
                   + ((64'(p[31:0]) * filt_weight[slot]) >> 16);
               s2 = {1'b0, sum} + {1'b0, t};
               sum = s2[64] ? '1 : s2[63:0];
            end
            slot = (slot + 1) % N_SLOTS;
         end
         r.band_out = mfl_pkg::BAND_W'(b);
         r.log_energy = pinned_valid ? pinned_log : ln_q9_of(sum);
         r.last_band = (b + 1 == nb);
         band_energy_q.push_back(r);
      end
   endtask

   task automatic apply_item(input req_item_type it);
      case (it.op)
         mfl_pkg::OP_BAND_SHAPE: begin
            shape_first[it.band] = it.first;
            shape_count[it.band] = it.cnt;
         end
         mfl_pkg::OP_WEIGHT: filt_weight[it.slot] = it.wval;
         mfl_pkg::OP_SPECTRUM: begin
            if (word_pos == 0) begin
               bin_power[0] = square_mag(it.re);
               bin_power[HALF_BINS] = square_mag(it.im);
            end else begin
               bin_power[word_pos] = square_mag(it.re) + square_mag(it.im);
            end
            if (word_pos + 1 < HALF_BINS) begin
               word_pos++;
            end else begin
               word_pos = 0;
               frames_done++;
               predict_band_energies();
            end
         end
         default: ;
      endcase
   endtask

   // monitor: predictor, result checker and activity count
   always @(posedge clock) begin
      req_item_type        it;
      mfl_pkg::result_type want;
      bit                  moved;
      int                  diff;
      moved = 1'b0;
      if (req_bus.valid && req_bus.ready) begin
         moved = 1'b1;
         it.op = req_bus.operation;     it.band = req_bus.band_number;
         it.first = req_bus.first_bin;  it.cnt = req_bus.weight_count;
         it.slot = req_bus.weight_slot; it.wval = req_bus.weight_value;
         it.re = req_bus.real_part;     it.im = req_bus.imag_part;
         apply_item(it);
      end
      if (csr_bus.valid && csr_bus.ready) begin
         moved = 1'b1;
         bands_cfg = csr_bus.bands_in_use;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
         moved = 1'b1;
         results_seen++;
         if (band_energy_q.size() == 0) begin
            report($sformatf("band %0d result with nothing expected", rsp_bus.band_out));
         end else begin
            want = band_energy_q.pop_front();
            diff = int'(rsp_bus.log_energy) - int'(want.log_energy);
            if (rsp_bus.band_out !== want.band_out)
               report($sformatf("band_out %0d, expected %0d", rsp_bus.band_out,
                                want.band_out));
            if (rsp_bus.last_band !== want.last_band)
               report($sformatf("band %0d last_band %0b, expected %0b", want.band_out,
                                rsp_bus.last_band, want.last_band));
            if ($isunknown(rsp_bus.log_energy) || diff > 1 || diff < -1)
               report($sformatf("band %0d log_energy %0d, expected %0d", want.band_out,
                                rsp_bus.log_energy, want.log_energy));
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
   end

   // result receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         int n;
         bit lvl;
         if (rsp_hold > 0) begin
            n = rsp_hold;
            rsp_hold = 0;
            lvl = 1'b0;
         end else begin
            case ($urandom_range(9))
               0:       begin lvl = 1'b0; n = $urandom_range(60, 20); end
               1, 2:    begin lvl = 1'b0; n = $urandom_range(3, 1); end
               3:       begin lvl = 1'b1; n = $urandom_range(200, 50); end
               default: begin lvl = 1'b1; n = $urandom_range(6, 1); end
            endcase
         end
         rsp_bus.ready <= lvl;
         repeat (n) @(posedge clock);
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   task automatic push_item(input req_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= it.op;     req_bus.band_number <= it.band;
      req_bus.first_bin <= it.first;  req_bus.weight_count <= it.cnt;
      req_bus.weight_slot <= it.slot; req_bus.weight_value <= it.wval;
      req_bus.real_part <= it.re;     req_bus.imag_part <= it.im;
      items_sent++;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // sender goes quiet until every band result is back and the walk is done
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (band_energy_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_band_count(input logic [mfl_pkg::CFG_W-1:0] v);
      csr_bus.valid <= 1'b1;
      csr_bus.bands_in_use <= v;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic req_item_type blank_item(input logic [mfl_pkg::OP_W-1:0] op);
      req_item_type it;
      it.op = op; it.band = '0; it.first = '0; it.cnt = '0;
      it.slot = '0; it.wval = '0; it.re = '0; it.im = '0;
      return it;
   endfunction

   function automatic req_item_type rand_shape(input int b, input bit mel_like);
      req_item_type it;
      it = blank_item(mfl_pkg::OP_BAND_SHAPE);
      it.band = mfl_pkg::BAND_W'(b);
      if (mel_like) begin
         it.first = mfl_pkg::BIN_W'(b * 15);
         it.cnt = mfl_pkg::CNT_W'($urandom_range(40, 8));
      end else begin
         it.first = mfl_pkg::BIN_W'($urandom_range(512));
         it.cnt = ($urandom_range(7) == 0) ? mfl_pkg::CNT_W'($urandom_range(513))
                                          : mfl_pkg::CNT_W'($urandom_range(48));
      end
      return it;
   endfunction

   function automatic req_item_type rand_weight(input int s);
      req_item_type it;
      it = blank_item(mfl_pkg::OP_WEIGHT);
      it.slot = mfl_pkg::SLOT_W'(s);
      case ($urandom_range(9))
         0:       it.wval = '0;
         1:       it.wval = '1;
         default: it.wval = mfl_pkg::WVAL_W'($urandom);
      endcase
      return it;
   endfunction

   function automatic logic [31:0] rand_part(input int style);
      case (style)
         0:       return $urandom;
         1:       return 32'($signed($urandom_range(2047)) - 1024);
         default: return ($urandom_range(3) == 0) ? 32'($urandom_range(255)) : $urandom;
      endcase
   endfunction

   // one frame of spectrum words with loads and stray codes mixed in
   task automatic spectrum_frame(input int style, input int hold_before_last);
      req_item_type it;
      int w;
      for (w = 0; w < HALF_BINS; w++) begin
         case ($urandom_range(49))
            0: push_item(rand_shape($urandom_range(31), 1'b0));
            1, 2: push_item(rand_weight($urandom_range(1023)));
            3: begin
               it = blank_item(OP_UNUSED);
               it.re = $urandom; it.im = $urandom;
               it.slot = mfl_pkg::SLOT_W'($urandom);
               push_item(it);
            end
            default: ;
         endcase
         it = blank_item(mfl_pkg::OP_SPECTRUM);
         it.re = rand_part(style);
         it.im = rand_part(style);
         if (w == HALF_BINS - 1 && hold_before_last > 0) rsp_hold = hold_before_last;
         push_item(it);
      end
   endtask

   stim_row_type dir_table [$];

   task automatic add_row(input req_item_type it, input int reps, input bit has_exp,
                          input logic [mfl_pkg::LOG_W-1:0] exp_log);
      stim_row_type row;
      row.it = it; row.reps = reps; row.has_exp = has_exp; row.exp_log = exp_log;
      dir_table.push_back(row);
   endtask

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin
      req_item_type it;
      int i, r, f;
      logic [mfl_pkg::CFG_W-1:0] band_settings [0:6];
      req_bus.valid = 1'b0;
      req_bus.operation = mfl_pkg::OP_SPECTRUM; req_bus.band_number = '0;
      req_bus.first_bin = '0; req_bus.weight_count = '0;
      req_bus.weight_slot = '0; req_bus.weight_value = '0;
      req_bus.real_part = '0; req_bus.imag_part = '0;
      csr_bus.valid = 1'b0;
      csr_bus.bands_in_use = '0;
      word_pos = 0;
      bands_cfg = mfl_pkg::BANDS_RESET;
      pinned_valid = 1'b0;
      pinned_log = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // fill every band shape and weight slot before any frame reads them
      for (i = 0; i < N_BANDS; i++) push_item(rand_shape(i, 1'b1));
      for (i = 0; i < N_SLOTS; i++) push_item(rand_weight(i));

      // directed table, run with the reset band count
      it = blank_item(mfl_pkg::OP_BAND_SHAPE);
      add_row(it, 1, 0, '0);                             // empty band 0
      it.band = 5'd31; it.first = 10'd512; it.cnt = 10'd513;
      add_row(it, 1, 0, '0);                             // band runs past nyquist
      it.band = 5'd1; it.first = 10'd0; it.cnt = 10'd513;
      add_row(it, 1, 0, '0);                             // band over every bin
      it = blank_item(mfl_pkg::OP_WEIGHT);
      it.slot = 10'd1023; it.wval = 16'hFFFF;
      add_row(it, 1, 0, '0);
      it.slot = 10'd0; it.wval = 16'h0000;
      add_row(it, 1, 0, '0);
      it.slot = 10'd1; it.wval = 16'hFFFF;
      add_row(it, 1, 0, '0);
      it = blank_item(OP_UNUSED);
      it.re = '1; it.im = '1; it.slot = '1; it.wval = '1;
      add_row(it, 1, 0, '0);                             // stray code, ignored
      it = blank_item(mfl_pkg::OP_SPECTRUM);
      it.re = 32'h8000_0000; it.im = 32'h7FFF_FFFF;
      add_row(it, 1, 0, '0);                             // dc and nyquist extremes
      it.re = '0; it.im = '0;
      add_row(it, 510, 0, '0);
      it.re = 32'h7FFF_FFFF; it.im = 32'h8000_0000;
      add_row(it, 1, 0, '0);
      it.re = '0; it.im = '0;
      add_row(it, 512, 1, '0);                           // silent frame: every band clamps
      it.re = 32'h8000_0000; it.im = 32'h8000_0000;
      add_row(it, 512, 0, '0);                           // full scale, sums saturate

      foreach (dir_table[d]) begin
         // earlier frames are predicted before a typed-in value takes over
         if (dir_table[d].has_exp) settle();
         pinned_valid = dir_table[d].has_exp;
         pinned_log = dir_table[d].exp_log;
         for (r = 0; r < dir_table[d].reps; r++) push_item(dir_table[d].it);
         if (dir_table[d].has_exp) begin
            settle();
            pinned_valid = 1'b0;
         end
      end
      settle();

      band_settings[0] = 6'd63; band_settings[1] = 6'd0;  band_settings[2] = 6'd1;
      band_settings[3] = 6'd32; band_settings[4] = 6'd17; band_settings[5] = 6'd30;
      band_settings[6] = mfl_pkg::CFG_W'($urandom_range(63));
      for (f = 0; f < 7; f++) begin
         write_band_count(band_settings[f]);
         no_gaps = (f == 2);
         for (i = 0; i < N_BANDS; i++) push_item(rand_shape(i, f % 2 == 0));
         for (i = 0; i < 40; i++) push_item(rand_weight($urandom_range(1023)));
         if (f == 3) begin
            // results back up behind a long stall while the next frame streams in
            spectrum_frame(2, 6000);
            spectrum_frame(0, 0);
         end else begin
            spectrum_frame(f % 3, 0);
         end
         settle();
      end
      no_gaps = 1'b0;

      req_bus.valid <= 1'b0;
      while (band_energy_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d frames and %0d band results from %0d items,", frames_done,
               results_seen, items_sent);
      $display("band counts from clamped low to clamped high, with stalls on both sides");
      if (errors == 0 && band_energy_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire
